/* rtl/core/atrf_pkg.sv */
// atrf_pkg: shared types and constants for the transmit-request framer
// beat structs for the payload and result channels, register indexes, header
// codes; no dependencies
package atrf_pkg;

    // largest payload length carried in one frame; longer requests are clamped
    localparam logic [7:0] MAX_PAYLOAD = 8'd238;

    localparam logic [7:0]  START_DELIM     = 8'h7E;
    localparam logic [7:0]  FRAME_TYPE      = 8'h10;
    localparam logic [15:0] LENGTH_OVERHEAD = 16'd14;
    localparam logic [7:0]  CHECK_BASE      = 8'hFF;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // output slot of one item: header bytes, then payload, then checksum
    localparam int SEQ_W = 5;

    typedef enum logic [SEQ_W-1:0] {
        SEQ_START    = 5'd0,
        SEQ_LEN_HI   = 5'd1,
        SEQ_LEN_LO   = 5'd2,
        SEQ_TYPE     = 5'd3,
        SEQ_FRAME_ID = 5'd4,
        SEQ_DL7      = 5'd5,
        SEQ_DL6      = 5'd6,
        SEQ_DL5      = 5'd7,
        SEQ_DL4      = 5'd8,
        SEQ_DL3      = 5'd9,
        SEQ_DL2      = 5'd10,
        SEQ_DL1      = 5'd11,
        SEQ_DL0      = 5'd12,
        SEQ_DS_HI    = 5'd13,
        SEQ_DS_LO    = 5'd14,
        SEQ_RADIUS   = 5'd15,
        SEQ_OPTIONS  = 5'd16,
        SEQ_PAYLOAD  = 5'd17,
        SEQ_CHECK    = 5'd18
    } t_seq;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_ID   = 3'd0,
        CFG_DEST_LONG  = 3'd1,
        CFG_DEST_SHORT = 3'd2,
        CFG_RADIUS     = 3'd3,
        CFG_OPTIONS    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] message_length;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       frame_end;
    } t_out_beat;

endpackage

/* rtl/core/api_transmit_request_framer.sv */
// api_transmit_request_framer: wraps a payload byte stream in transmit-request
// frames (header, payload, checksum); depends on atrf_pkg
//
// usage:
//   payload channel (i_in_valid / o_in_ready / i_in_data) takes one payload
//   byte per beat; message_length is sampled on the first beat of a frame.
//   result channel (o_out_valid / i_out_ready / o_out_data) gives one framed
//   byte per beat; last_of_run marks the final byte caused by an input beat,
//   frame_end marks the closing checksum.
//   configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data),
//   written while the block is idle; unknown indexes are dropped.
// flow:
//   an accepted beat sits in a holding register and its bytes leave through
//   the output register, one per cycle while the receiver is ready. a mid-frame
//   beat gives one byte, the last beat of a frame two, the first beat of a
//   frame 18 (17 header bytes plus payload), 19 for a one-byte frame. the
//   holding register frees in the cycle its last byte is loaded, so mid-frame
//   beats stream at one per cycle while the receiver keeps up.
// reset clears both registers' valid flags, the frame state and the config
// registers to their defaults; a stalled receiver holds the output byte and,
// once the holding register is busy, drops o_in_ready.
module api_transmit_request_framer #(
    parameter logic [7:0] MAX_PAYLOAD = atrf_pkg::MAX_PAYLOAD
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  atrf_pkg::t_in_beat             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output atrf_pkg::t_out_beat            o_out_data,
    input  logic                           i_cfg_we,
    input  logic [atrf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [atrf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [7:0]  r_frame_id;
    logic [63:0] r_dest_long;
    logic [15:0] r_dest_short;
    logic [7:0]  r_radius;
    logic [7:0]  r_options;

    // holding register
    logic               r_hold_valid;
    atrf_pkg::t_in_beat r_hold;
    atrf_pkg::t_seq     r_seq;

    // frame state
    logic       r_inside;
    logic [7:0] r_remaining;
    logic [7:0] r_sum;

    // output register
    logic                r_out_valid;
    atrf_pkg::t_out_beat r_out;

    logic                can_load;
    logic                gen;
    logic                item_done;
    atrf_pkg::t_seq      cur_seq;
    atrf_pkg::t_seq      n_seq;
    logic [7:0]          len_eff;
    logic [15:0]         total;
    logic [7:0]          rem_after;
    logic [7:0]          gen_byte;
    logic                summed;
    atrf_pkg::t_out_beat n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_id   <= 8'd1;
            r_dest_long  <= 64'd0;
            r_dest_short <= 16'hFFFE;
            r_radius     <= 8'd0;
            r_options    <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                atrf_pkg::CFG_FRAME_ID:   r_frame_id   <= i_cfg_data[7:0];
                atrf_pkg::CFG_DEST_LONG:  r_dest_long  <= i_cfg_data[63:0];
                atrf_pkg::CFG_DEST_SHORT: r_dest_short <= i_cfg_data[15:0];
                atrf_pkg::CFG_RADIUS:     r_radius     <= i_cfg_data[7:0];
                atrf_pkg::CFG_OPTIONS:    r_options    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        can_load = !r_out_valid || i_out_ready;
        gen      = r_hold_valid && can_load;

        // a beat inside a frame skips the header
        if (r_seq == atrf_pkg::SEQ_START && r_inside) begin
            cur_seq = atrf_pkg::SEQ_PAYLOAD;
        end else begin
            cur_seq = r_seq;
        end

        if (r_hold.message_length > MAX_PAYLOAD) begin
            len_eff = MAX_PAYLOAD;
        end else if (r_hold.message_length == 8'd0) begin
            len_eff = 8'd1;
        end else begin
            len_eff = r_hold.message_length;
        end
        total = {8'd0, len_eff} + atrf_pkg::LENGTH_OVERHEAD;

        if (!r_inside) begin
            rem_after = len_eff - 8'd1;
        end else if (r_remaining != 8'd0) begin
            rem_after = r_remaining - 8'd1;
        end else begin
            rem_after = 8'd0;
        end

        summed = 1'b1;
        case (cur_seq)
            atrf_pkg::SEQ_START: begin
                gen_byte = atrf_pkg::START_DELIM;
                summed   = 1'b0;
            end
            atrf_pkg::SEQ_LEN_HI: begin
                gen_byte = total[15:8];
                summed   = 1'b0;
            end
            atrf_pkg::SEQ_LEN_LO: begin
                gen_byte = total[7:0];
                summed   = 1'b0;
            end
            atrf_pkg::SEQ_TYPE:     gen_byte = atrf_pkg::FRAME_TYPE;
            atrf_pkg::SEQ_FRAME_ID: gen_byte = r_frame_id;
            atrf_pkg::SEQ_DL7:      gen_byte = r_dest_long[63:56];
            atrf_pkg::SEQ_DL6:      gen_byte = r_dest_long[55:48];
            atrf_pkg::SEQ_DL5:      gen_byte = r_dest_long[47:40];
            atrf_pkg::SEQ_DL4:      gen_byte = r_dest_long[39:32];
            atrf_pkg::SEQ_DL3:      gen_byte = r_dest_long[31:24];
            atrf_pkg::SEQ_DL2:      gen_byte = r_dest_long[23:16];
            atrf_pkg::SEQ_DL1:      gen_byte = r_dest_long[15:8];
            atrf_pkg::SEQ_DL0:      gen_byte = r_dest_long[7:0];
            atrf_pkg::SEQ_DS_HI:    gen_byte = r_dest_short[15:8];
            atrf_pkg::SEQ_DS_LO:    gen_byte = r_dest_short[7:0];
            atrf_pkg::SEQ_RADIUS:   gen_byte = r_radius;
            atrf_pkg::SEQ_OPTIONS:  gen_byte = r_options;
            atrf_pkg::SEQ_PAYLOAD:  gen_byte = r_hold.payload_byte;
            atrf_pkg::SEQ_CHECK: begin
                gen_byte = atrf_pkg::CHECK_BASE - r_sum;
                summed   = 1'b0;
            end
            default: begin
                gen_byte = 8'd0;
                summed   = 1'b0;
            end
        endcase

        // the payload slot closes the item unless the frame ends here
        item_done = (cur_seq == atrf_pkg::SEQ_CHECK) ||
                    (cur_seq == atrf_pkg::SEQ_PAYLOAD && rem_after != 8'd0);

        n_seq = atrf_pkg::t_seq'(cur_seq + 5'd1);

        n_out.out_byte    = gen_byte;
        n_out.last_of_run = item_done;
        n_out.frame_end   = (cur_seq == atrf_pkg::SEQ_CHECK);

        o_in_ready = !r_hold_valid || (gen && item_done);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_seq        <= atrf_pkg::SEQ_START;
        end else if (i_in_valid && o_in_ready) begin
            r_hold_valid <= 1'b1;
            r_seq        <= atrf_pkg::SEQ_START;
        end else if (gen && item_done) begin
            r_hold_valid <= 1'b0;
        end else if (gen) begin
            r_seq <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_hold <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside    <= 1'b0;
            r_remaining <= 8'd0;
            r_sum       <= 8'd0;
        end else if (gen) begin
            if (cur_seq == atrf_pkg::SEQ_START) begin
                r_sum <= 8'd0;
            end else if (cur_seq == atrf_pkg::SEQ_CHECK) begin
                r_sum <= 8'd0;
            end else if (summed) begin
                r_sum <= r_sum + gen_byte;
            end
            if (cur_seq == atrf_pkg::SEQ_PAYLOAD) begin
                r_inside    <= (rem_after != 8'd0);
                r_remaining <= rem_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_load) begin
            r_out_valid <= gen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/core/atrf_checker.sv */
// atrf_checker: port-level checks on the transmit-request framer
// bound to api_transmit_request_framer; depends on atrf_pkg
module atrf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input atrf_pkg::t_out_beat o_out_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // the checksum always closes the run of its input beat
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_end |-> o_out_data.last_of_run)
        else $error("checksum beat without last_of_run");

    // a checksum beat is never followed directly by another checksum
    a_no_double_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.frame_end
        |=> !(o_out_valid && o_out_data.frame_end))
        else $error("two checksum beats in a row");

    // nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind api_transmit_request_framer atrf_checker u_atrf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

/* test/api_transmit_request_framer_test.sv */
`timescale 1ns / 100ps
// api_transmit_request_framer_test: self-checking bench for the transmit-request framer
// directed table then random frames, checked against a framing predictor kept here;
// depends on atrf_pkg and api_transmit_request_framer
module api_transmit_request_framer_test;

    localparam int          CYCLE_LIMIT = 500_000;
    localparam int          PHASE_ITEMS = 153;
    localparam int          END_SETTLE  = 40;
    localparam int          DIR_ROWS    = 18;
    localparam logic [atrf_pkg::CFG_IDX_W-1:0] CFG_BAD_FIRST = 3'd5;
    localparam logic [atrf_pkg::CFG_IDX_W-1:0] CFG_BAD_LAST  = 3'd7;

    typedef enum logic {ROW_BEAT, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind                      kind;
        logic [atrf_pkg::CFG_IDX_W-1:0] reg_index;
        logic [63:0]                    reg_value;
        logic [7:0]                     payload;
        logic [7:0]                     length;
        logic                           known;
        logic [7:0]                     tail;
    } t_plan_row;

    // tail is the last byte an input beat must produce, where it is obvious
    localparam t_plan_row DIRECTED_PLAN [DIR_ROWS] = '{
        '{ROW_BEAT, atrf_pkg::CFG_FRAME_ID, 64'd0, 8'h00, 8'd1, 1'b1, 8'hF1},
        '{ROW_BEAT, atrf_pkg::CFG_FRAME_ID, 64'd0, 8'hFF, 8'd0, 1'b1, 8'hF2},
        '{ROW_BEAT, atrf_pkg::CFG_FRAME_ID, 64'd0, 8'h5A, 8'd3, 1'b1, 8'h5A},
        '{ROW_BEAT, atrf_pkg::CFG_FRAME_ID, 64'd0, 8'hA5, 8'd200, 1'b1, 8'hA5},
        '{ROW_REG, atrf_pkg::CFG_FRAME_ID, 64'hFF, 8'h00, 8'd0, 1'b0, 8'h00},
        '{ROW_BEAT, atrf_pkg::CFG_FRAME_ID, 64'd0, 8'h3C, 8'd0, 1'b1, 8'hB6},
        '{ROW_REG, atrf_pkg::CFG_DEST_LONG, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'd0, 1'b0, 8'h00},
        '{ROW_REG, atrf_pkg::CFG_DEST_SHORT, 64'd0, 8'h00, 8'd0, 1'b0, 8'h00},
        '{ROW_REG, atrf_pkg::CFG_RADIUS, 64'hFF, 8'h00, 8'd0, 1'b0, 8'h00},
        '{ROW_REG, atrf_pkg::CFG_OPTIONS, 64'hFF, 8'h00, 8'd0, 1'b0, 8'h00},
        '{ROW_REG, CFG_BAD_FIRST, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'd0, 1'b0, 8'h00},
        '{ROW_REG, CFG_BAD_LAST, 64'd0, 8'h00, 8'd0, 1'b0, 8'h00},
        '{ROW_BEAT, atrf_pkg::CFG_FRAME_ID, 64'd0, 8'h00, 8'd1, 1'b1, 8'hFA},
        '{ROW_REG, atrf_pkg::CFG_FRAME_ID, 64'd0, 8'h00, 8'd0, 1'b0, 8'h00},
        '{ROW_BEAT, atrf_pkg::CFG_FRAME_ID, 64'd0, 8'h80, 8'd2, 1'b0, 8'h00},
        '{ROW_BEAT, atrf_pkg::CFG_FRAME_ID, 64'd0, 8'h01, 8'd77, 1'b0, 8'h00},
        '{ROW_BEAT, atrf_pkg::CFG_FRAME_ID, 64'd0, 8'h7F, 8'd1, 1'b0, 8'h00},
        '{ROW_BEAT, atrf_pkg::CFG_FRAME_ID, 64'd0, 8'hC3, 8'd255, 1'b0, 8'h00}
    };

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    atrf_pkg::t_in_beat              in_data   = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    atrf_pkg::t_out_beat             out_data;
    logic                            cfg_we    = 1'b0;
    logic [atrf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [atrf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // header fields as the block should hold them
    logic [7:0]  hdr_frame_id   = 8'd1;
    logic [63:0] hdr_dest_long  = 64'd0;
    logic [15:0] hdr_dest_short = 16'hFFFE;
    logic [7:0]  hdr_radius     = 8'd0;
    logic [7:0]  hdr_options    = 8'd0;

    // framing state
    logic        in_frame   = 1'b0;
    logic [7:0]  bytes_left = 8'd0;
    logic [7:0]  frame_sum  = 8'd0;

    atrf_pkg::t_out_beat pending_bytes [$];
    int          error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned beat_count    = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;

    api_transmit_request_framer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("ERROR: timeout after %0d cycles", cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic void push_byte(input logic [7:0] value, input logic summed,
                                      input logic closes);
        atrf_pkg::t_out_beat r;
        r.out_byte    = value;
        r.last_of_run = 1'b0;
        r.frame_end   = closes;
        if (summed)
            frame_sum = frame_sum + value;
        pending_bytes.push_back(r);
    endfunction

    // bytes produced by one accepted payload beat
    function automatic void predict_frame_bytes(input atrf_pkg::t_in_beat beat);
        logic [7:0]          len;
        logic [15:0]         total;
        atrf_pkg::t_out_beat r;
        if (!in_frame) begin
            len = beat.message_length;
            if (len > atrf_pkg::MAX_PAYLOAD)
                len = atrf_pkg::MAX_PAYLOAD;
            if (len == 8'd0)
                len = 8'd1;
            total = {8'd0, len} + atrf_pkg::LENGTH_OVERHEAD;
            frame_sum = 8'd0;
            push_byte(atrf_pkg::START_DELIM, 1'b0, 1'b0);
            push_byte(total[15:8], 1'b0, 1'b0);
            push_byte(total[7:0], 1'b0, 1'b0);
            push_byte(atrf_pkg::FRAME_TYPE, 1'b1, 1'b0);
            push_byte(hdr_frame_id, 1'b1, 1'b0);
            for (int b = 7; b >= 0; b--)
                push_byte(hdr_dest_long[b*8 +: 8], 1'b1, 1'b0);
            push_byte(hdr_dest_short[15:8], 1'b1, 1'b0);
            push_byte(hdr_dest_short[7:0], 1'b1, 1'b0);
            push_byte(hdr_radius, 1'b1, 1'b0);
            push_byte(hdr_options, 1'b1, 1'b0);
            in_frame   = 1'b1;
            bytes_left = len;
        end
        push_byte(beat.payload_byte, 1'b1, 1'b0);
        if (bytes_left != 8'd0)
            bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) begin
            push_byte(atrf_pkg::CHECK_BASE - frame_sum, 1'b0, 1'b1);
            in_frame  = 1'b0;
            frame_sum = 8'd0;
        end
        r = pending_bytes.pop_back();
        r.last_of_run = 1'b1;
        pending_bytes.push_back(r);
    endfunction

    task automatic send_beat(input atrf_pkg::t_in_beat beat);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (!in_ready);
        predict_frame_bytes(beat);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [atrf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            atrf_pkg::CFG_FRAME_ID:   hdr_frame_id   = value[7:0];
            atrf_pkg::CFG_DEST_LONG:  hdr_dest_long  = value;
            atrf_pkg::CFG_DEST_SHORT: hdr_dest_short = value[15:0];
            atrf_pkg::CFG_RADIUS:     hdr_radius     = value[7:0];
            atrf_pkg::CFG_OPTIONS:    hdr_options    = value[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_regs(input logic all_zero);
        wait_drained();
        write_reg(atrf_pkg::CFG_FRAME_ID, all_zero ? 64'd0 : {$urandom, $urandom});
        write_reg(atrf_pkg::CFG_DEST_LONG, all_zero ? 64'd0 : {$urandom, $urandom});
        write_reg(atrf_pkg::CFG_DEST_SHORT, all_zero ? 64'd0 : {$urandom, $urandom});
        write_reg(atrf_pkg::CFG_RADIUS, all_zero ? 64'd0 : {$urandom, $urandom});
        write_reg(atrf_pkg::CFG_OPTIONS, all_zero ? 64'd0 : {$urandom, $urandom});
        write_reg(3'($urandom_range(CFG_BAD_LAST, CFG_BAD_FIRST)), {$urandom, $urandom});
    endtask

    // mostly short frames, with zero, exact-max and oversize lengths mixed in
    function automatic logic [7:0] pick_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 8'($urandom_range(6, 1));
        else if (roll < 84)
            return 8'($urandom_range(40, 7));
        else if (roll < 90)
            return 8'd0;
        else if (roll < 95)
            return 8'($urandom_range(255, 239));
        return atrf_pkg::MAX_PAYLOAD;
    endfunction

    task automatic run_phase(input int idle_pct, input int ready_stall_pct);
        atrf_pkg::t_in_beat beat;
        int                 pause_at;
        send_idle_pct = idle_pct;
        stall_pct     = ready_stall_pct;
        pause_at      = $urandom_range(PHASE_ITEMS - 20, 20);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            // let the output side run dry once per phase
            if (n == pause_at)
                wait_drained();
            beat.payload_byte   = 8'($urandom_range(255));
            beat.message_length = in_frame ? 8'($urandom_range(255)) : pick_length();
            send_beat(beat);
        end
    endtask

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        atrf_pkg::t_out_beat want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_bytes.size() == 0) begin
                report_error($sformatf("unexpected beat %0d, byte %h",
                                       beat_count, out_data.out_byte));
            end else begin
                want = pending_bytes.pop_front();
                if (out_data.out_byte !== want.out_byte)
                    report_error($sformatf("beat %0d out_byte %h, want %h", beat_count,
                                           out_data.out_byte, want.out_byte));
                if (out_data.last_of_run !== want.last_of_run)
                    report_error($sformatf("beat %0d last_of_run %b, want %b", beat_count,
                                           out_data.last_of_run, want.last_of_run));
                if (out_data.frame_end !== want.frame_end)
                    report_error($sformatf("beat %0d frame_end %b, want %b", beat_count,
                                           out_data.frame_end, want.frame_end));
            end
            beat_count <= beat_count + 1;
        end
    end

    initial begin
        atrf_pkg::t_in_beat  beat;
        atrf_pkg::t_out_beat tail_beat;
        t_plan_row           row;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 25;
        stall_pct     = 25;
        for (int i = 0; i < DIR_ROWS; i++) begin
            row = DIRECTED_PLAN[i];
            if (row.kind == ROW_REG) begin
                wait_drained();
                write_reg(row.reg_index, row.reg_value);
            end else begin
                beat.payload_byte   = row.payload;
                beat.message_length = row.length;
                send_beat(beat);
                if (row.known) begin
                    tail_beat = pending_bytes.pop_back();
                    tail_beat.out_byte = row.tail;
                    pending_bytes.push_back(tail_beat);
                end
            end
        end

        // the directed part leaves an oversize frame open; the random phases close it
        program_regs(1'b0);
        run_phase(12, 87);
        program_regs(1'b1);
        run_phase(87, 12);
        program_regs(1'b0);
        run_phase(0, 0);

        wait_drained();
        repeat (END_SETTLE) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
